FILE: rtl/gps_lnav_subframe_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// GPS LNAV subframe decoder assertion macros
// Shared property forms for the checkers; clk and arst_n come from the scope.
// ----------------------------------------------------------------------------
`ifndef GPS_LNAV_SUBFRAME_DECODER_UNIT_MACROS_SVH
`define GPS_LNAV_SUBFRAME_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define GLSD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLSD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/glsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS LNAV subframe decoder package
// Types, status codes, parity masks and the ephemeris/clock field table.
// ----------------------------------------------------------------------------
package glsd_pkg;

	localparam int WORDS_PER_SUBFRAME = 10;
	localparam int DATA_BITS = 24;
	localparam int DIGIT_BITS = 8;
	localparam int DATA_DIGITS = DATA_BITS / DIGIT_BITS;
	localparam int STORE_DEPTH = WORDS_PER_SUBFRAME - 2;
	localparam int STORE_AW = $clog2(STORE_DEPTH);

	localparam logic [3:0] TLM_INDEX = 4'd0;
	localparam logic [3:0] HOW_INDEX = 4'd1;
	localparam logic [3:0] FIRST_DATA_INDEX = 4'd2;
	localparam logic [3:0] LAST_INDEX = 4'(WORDS_PER_SUBFRAME - 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PARITY = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;
	localparam logic [1:0] ST_SUBFRAME = 2'd3;

	localparam logic [2:0] SF_CLOCK = 3'd1;
	localparam logic [2:0] SF_EPH_A = 3'd2;
	localparam logic [2:0] SF_EPH_B = 3'd3;

	localparam logic [4:0] FIRST_ID_SF1 = 5'd0;
	localparam logic [4:0] LAST_ID_SF1 = 5'd9;
	localparam logic [4:0] FIRST_ID_SF2 = 5'd10;
	localparam logic [4:0] LAST_ID_SF2 = 5'd20;
	localparam logic [4:0] FIRST_ID_SF3 = 5'd21;
	localparam logic [4:0] LAST_ID_SF3 = 5'd29;

	localparam logic [23:0] PAR_MASK [6] = '{
		24'hEC7CD2, 24'h763E69, 24'hBB1F34, 24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27
	};

	typedef struct packed {
		logic                 load;
		logic [DATA_BITS-1:0] data;
		logic                 d29;
		logic                 d30;
		logic [5:0]           chk;
	} par_load_t;

	typedef struct packed {
		logic done;
		logic fail;
	} par_res_t;

	typedef struct packed {
		logic                 en;
		logic [STORE_AW-1:0]  addr;
		logic [DATA_BITS-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic       go;
		logic [1:0] status;
		logic [4:0] first_id;
		logic [4:0] last_id;
		logic [2:0] subframe;
	} emit_cmd_t;

	typedef struct packed {
		logic [3:0] hw;
		logic [4:0] hs;
		logic [4:0] hl;
		logic [3:0] lw;
		logic [4:0] ls;
		logic [4:0] ll;
		logic       sg;
	} field_desc_t;

	function automatic field_desc_t glsd_fd(input int hw, input int hs, input int hl,
		input int lw, input int ls, input int ll, input int sg);
		field_desc_t d;
		d.hw = 4'(hw);
		d.hs = 5'(hs);
		d.hl = 5'(hl);
		d.lw = 4'(lw);
		d.ls = 5'(ls);
		d.ll = 5'(ll);
		d.sg = 1'(sg);
		return d;
	endfunction

	function automatic field_desc_t glsd_field(input logic [4:0] id);
		field_desc_t d;
		case (id)
			5'd0: d = glsd_fd(3, 1, 10, 0, 0, 0, 0);
			5'd1: d = glsd_fd(3, 11, 2, 0, 0, 0, 0);
			5'd2: d = glsd_fd(3, 13, 4, 0, 0, 0, 0);
			5'd3: d = glsd_fd(3, 17, 6, 0, 0, 0, 0);
			5'd4: d = glsd_fd(3, 23, 2, 8, 1, 8, 0);
			5'd5: d = glsd_fd(7, 17, 8, 0, 0, 0, 1);
			5'd6: d = glsd_fd(8, 9, 16, 0, 0, 0, 0);
			5'd7: d = glsd_fd(9, 1, 8, 0, 0, 0, 1);
			5'd8: d = glsd_fd(9, 9, 16, 0, 0, 0, 1);
			5'd9: d = glsd_fd(10, 1, 22, 0, 0, 0, 1);
			5'd10: d = glsd_fd(3, 1, 8, 0, 0, 0, 0);
			5'd11: d = glsd_fd(3, 9, 16, 0, 0, 0, 1);
			5'd12: d = glsd_fd(4, 1, 16, 0, 0, 0, 1);
			5'd13: d = glsd_fd(4, 17, 8, 5, 1, 24, 1);
			5'd14: d = glsd_fd(6, 1, 16, 0, 0, 0, 1);
			5'd15: d = glsd_fd(6, 17, 8, 7, 1, 24, 0);
			5'd16: d = glsd_fd(8, 1, 16, 0, 0, 0, 1);
			5'd17: d = glsd_fd(8, 17, 8, 9, 1, 24, 0);
			5'd18: d = glsd_fd(10, 1, 16, 0, 0, 0, 0);
			5'd19: d = glsd_fd(10, 17, 1, 0, 0, 0, 0);
			5'd20: d = glsd_fd(10, 18, 5, 0, 0, 0, 0);
			5'd21: d = glsd_fd(3, 1, 16, 0, 0, 0, 1);
			5'd22: d = glsd_fd(3, 17, 8, 4, 1, 24, 1);
			5'd23: d = glsd_fd(5, 1, 16, 0, 0, 0, 1);
			5'd24: d = glsd_fd(5, 17, 8, 6, 1, 24, 1);
			5'd25: d = glsd_fd(7, 1, 16, 0, 0, 0, 1);
			5'd26: d = glsd_fd(7, 17, 8, 8, 1, 24, 1);
			5'd27: d = glsd_fd(9, 1, 24, 0, 0, 0, 1);
			5'd28: d = glsd_fd(10, 1, 8, 0, 0, 0, 0);
			5'd29: d = glsd_fd(10, 9, 14, 0, 0, 0, 1);
			default: d = glsd_fd(3, 1, 1, 0, 0, 0, 0);
		endcase
		return d;
	endfunction

	function automatic logic [31:0] glsd_low_mask(input logic [5:0] n);
		return ~(32'hFFFF_FFFF << n);
	endfunction

	function automatic logic [5:0] glsd_digit_parity(input logic [DIGIT_BITS-1:0] digit,
		input logic [1:0] step);
		logic [5:0] r;
		logic [DIGIT_BITS-1:0] m;
		r = '0;
		for (int i = 0; i < 6; i++) begin
			case (step)
				2'd0: m = PAR_MASK[i][23:16];
				2'd1: m = PAR_MASK[i][15:8];
				default: m = PAR_MASK[i][7:0];
			endcase
			r[5-i] = ^(digit & m);
		end
		return r;
	endfunction

endpackage

FILE: rtl/glsd_parity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GLSD parity checker
// Folds the 24 data bits one 8-bit digit per cycle into the six parity sums.
// ----------------------------------------------------------------------------
module glsd_parity
	import glsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  par_load_t ld,
	output par_res_t  res
);

	logic [DATA_BITS-1:0] sh_q;
	logic [5:0]           acc_q;
	logic [1:0]           cnt_q;
	logic                 run_q;
	logic                 d29_q;
	logic                 d30_q;
	logic [5:0]           chk_q;
	logic                 done_q;
	logic                 fail_q;
	logic [5:0]           acc_next;
	logic [5:0]           seed;

	assign acc_next = acc_q ^ glsd_digit_parity(sh_q[DATA_BITS-1 -: DIGIT_BITS], cnt_q);
	assign seed = {d29_q, d30_q, d29_q, d30_q, d30_q, d29_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !ld.load && run_q && (cnt_q == 2'(DATA_DIGITS - 1));
			if (ld.load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 2'(DATA_DIGITS - 1)) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			sh_q <= ld.data;
			acc_q <= '0;
			d29_q <= ld.d29;
			d30_q <= ld.d30;
			chk_q <= ld.chk;
		end else if (run_q) begin
			sh_q <= sh_q << DIGIT_BITS;
			acc_q <= acc_next;
			if (cnt_q == 2'(DATA_DIGITS - 1)) begin
				fail_q <= (acc_next ^ seed) != chk_q;
			end
		end
	end

	assign res.done = done_q;
	assign res.fail = fail_q;

endmodule

FILE: rtl/glsd_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GLSD field emitter
// Holds the data word store and walks the field table, one field at a time.
// ----------------------------------------------------------------------------
module glsd_emitter
	import glsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mem_wr_t            wr,
	input  emit_cmd_t          cmd,
	output logic               busy,
	input  logic               field_stall,
	output logic               field_valid,
	output logic [4:0]         field_id,
	output logic signed [32:0] field_value,
	output logic [2:0]         subframe_number,
	output logic [1:0]         status,
	output logic               last
);

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_RD = 2'd1;
	localparam logic [1:0] E_EXT = 2'd2;
	localparam logic [1:0] E_OUT = 2'd3;

	logic [DATA_BITS-1:0] mem [STORE_DEPTH];
	logic [DATA_BITS-1:0] rd_hi_q;
	logic [DATA_BITS-1:0] rd_lo_q;
	logic [31:0]          hi_q;
	logic [31:0]          lo_q;

	logic [1:0]  state_q;
	logic [4:0]  cur_id_q;
	logic [4:0]  last_id_q;
	logic [1:0]  st_q;
	logic [2:0]  sub_q;

	logic               out_valid_q;
	logic [4:0]         out_id_q;
	logic signed [32:0] out_value_q;
	logic [2:0]         out_sub_q;
	logic [1:0]         out_st_q;
	logic               out_last_q;

	field_desc_t desc;
	logic        rd_en;
	logic        out_free;
	logic [4:0]  hi_sh;
	logic [4:0]  lo_sh;
	logic [5:0]  total;
	logic [31:0] joined;
	logic        neg;
	logic [32:0] value;

	assign desc = glsd_field(cur_id_q);
	assign rd_en = state_q == E_RD;
	assign out_free = !out_valid_q || !field_stall;
	assign hi_sh = 5'd25 - desc.hs - desc.hl;
	assign lo_sh = 5'd25 - desc.ls - desc.ll;
	assign total = {1'b0, desc.hl} + {1'b0, desc.ll};
	assign joined = (desc.ll != 5'd0) ? ((hi_q << desc.ll) | lo_q) : hi_q;
	assign neg = desc.sg && joined[5'(total - 6'd1)];
	assign value = {1'b0, joined} | (neg ? ~{1'b0, glsd_low_mask(total)} : 33'd0);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_hi_q <= mem[STORE_AW'(desc.hw - 4'd3)];
			rd_lo_q <= mem[STORE_AW'(desc.lw - 4'd3)];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_EXT) begin
			hi_q <= ({8'd0, rd_hi_q} >> hi_sh) & glsd_low_mask({1'b0, desc.hl});
			lo_q <= ({8'd0, rd_lo_q} >> lo_sh) & glsd_low_mask({1'b0, desc.ll});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == E_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!field_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				E_IDLE: begin
					if (cmd.go) begin
						state_q <= (cmd.status == ST_OK) ? E_RD : E_OUT;
					end
				end
				E_RD: state_q <= E_EXT;
				E_EXT: state_q <= E_OUT;
				E_OUT: begin
					if (out_free) begin
						if (st_q != ST_OK || cur_id_q == last_id_q) begin
							state_q <= E_IDLE;
						end else begin
							state_q <= E_RD;
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && cmd.go) begin
			cur_id_q <= cmd.first_id;
			last_id_q <= cmd.last_id;
			st_q <= cmd.status;
			sub_q <= cmd.subframe;
		end else if (state_q == E_OUT && out_free) begin
			cur_id_q <= cur_id_q + 5'd1;
		end
		if (state_q == E_OUT && out_free) begin
			out_sub_q <= sub_q;
			out_st_q <= st_q;
			if (st_q != ST_OK) begin
				out_id_q <= 5'd0;
				out_value_q <= '0;
				out_last_q <= 1'b1;
			end else begin
				out_id_q <= cur_id_q;
				out_value_q <= value;
				out_last_q <= cur_id_q == last_id_q;
			end
		end
	end

	assign busy = state_q != E_IDLE;
	assign field_valid = out_valid_q;
	assign field_id = out_id_q;
	assign field_value = out_value_q;
	assign subframe_number = out_sub_q;
	assign status = out_st_q;
	assign last = out_last_q;

endmodule

FILE: rtl/gps_lnav_subframe_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS LNAV subframe decoder
// Checks word parity, buffers data words, emits raw ephemeris and clock fields.
// ----------------------------------------------------------------------------
// channel | signals                                              | flow
// nav     | nav_valid, nav_stall, nav_word, word_index, sat_number | in
// field   | field_valid, field_stall, field_id, field_value,     | out
//         | subframe_number, status, last                        |
//
// A data word (index 2..9) passes through the accept, three 8-bit digits
// through the parity shift register, and a final step to fold in the result.
// Telemetry, handover and out-of-range words are handled in the accept alone.
// Word 9 adds a decide state, then each field passes store read, extract and
// join, and the join can be held by field_stall.
// arst_n clears all control state; field_stall holds the output register and
// the field walk, and nav_stall stays high until the walk has finished.
// ----------------------------------------------------------------------------
module gps_lnav_subframe_decoder_unit
	import glsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nav_valid,
	output logic               nav_stall,
	input  logic [29:0]        nav_word,
	input  logic [3:0]         word_index,
	input  logic [5:0]         sat_number,
	output logic               field_valid,
	input  logic               field_stall,
	output logic [4:0]         field_id,
	output logic signed [32:0] field_value,
	output logic [2:0]         subframe_number,
	output logic [1:0]         status,
	output logic               last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PARITY = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] prev_q;
	logic [2:0] sub_q;
	logic       pf_q;
	logic [5:0] tracked_q;
	logic [5:0] sat_q;
	logic       end_word_q;

	logic       accept;
	logic       emit_busy;
	logic [5:0] bound;
	par_load_t  pld;
	par_res_t   pres;
	mem_wr_t    wr;
	emit_cmd_t  cmd;

	assign nav_stall = (state_q != S_IDLE) || emit_busy;
	assign accept = nav_valid && !nav_stall;

	always_comb begin
		pld.load = accept && (word_index inside {[FIRST_DATA_INDEX:LAST_INDEX]});
		pld.data = nav_word[29:6] ^ {DATA_BITS{prev_q[0]}};
		pld.d29 = prev_q[1];
		pld.d30 = prev_q[0];
		pld.chk = nav_word[5:0];
		wr.en = pld.load;
		wr.addr = STORE_AW'(word_index - FIRST_DATA_INDEX);
		wr.data = pld.data;
	end

	always_comb begin
		bound = (tracked_q == 6'd0) ? sat_q : tracked_q;
		cmd.go = state_q == S_DECIDE;
		cmd.subframe = sub_q;
		cmd.first_id = FIRST_ID_SF1;
		cmd.last_id = LAST_ID_SF1;
		cmd.status = ST_OK;
		if (pf_q) begin
			cmd.status = ST_PARITY;
		end else if (bound != sat_q) begin
			cmd.status = ST_SAT;
		end else begin
			case (sub_q)
				SF_CLOCK: begin
					cmd.first_id = FIRST_ID_SF1;
					cmd.last_id = LAST_ID_SF1;
				end
				SF_EPH_A: begin
					cmd.first_id = FIRST_ID_SF2;
					cmd.last_id = LAST_ID_SF2;
				end
				SF_EPH_B: begin
					cmd.first_id = FIRST_ID_SF3;
					cmd.last_id = LAST_ID_SF3;
				end
				default: cmd.status = ST_SUBFRAME;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_q <= '0;
			sub_q <= '0;
			pf_q <= 1'b0;
			tracked_q <= '0;
			end_word_q <= 1'b0;
			sat_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (word_index == TLM_INDEX) begin
							pf_q <= 1'b0;
						end else if (word_index == HOW_INDEX) begin
							sub_q <= nav_word[10:8];
							prev_q <= nav_word[1:0];
						end else if (pld.load) begin
							prev_q <= nav_word[1:0];
							sat_q <= sat_number;
							end_word_q <= word_index == LAST_INDEX;
							state_q <= S_PARITY;
						end
					end
				end
				S_PARITY: begin
					if (pres.done) begin
						if (pres.fail) begin
							pf_q <= 1'b1;
						end
						state_q <= end_word_q ? S_DECIDE : S_IDLE;
					end
				end
				S_DECIDE: begin
					if (!pf_q && tracked_q == 6'd0) begin
						tracked_q <= sat_q;
					end
					pf_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	glsd_parity u_parity (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (pld),
		.res    (pres)
	);

	glsd_emitter u_emitter (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr              (wr),
		.cmd             (cmd),
		.busy            (emit_busy),
		.field_stall     (field_stall),
		.field_valid     (field_valid),
		.field_id        (field_id),
		.field_value     (field_value),
		.subframe_number (subframe_number),
		.status          (status),
		.last            (last)
	);

endmodule

FILE: rtl/glsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GLSD port checker
// Watches the result channel of the decoder for consistent transactions.
// ----------------------------------------------------------------------------
`include "gps_lnav_subframe_decoder_unit_macros.svh"

module glsd_checker
	import glsd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               nav_valid,
	input logic               nav_stall,
	input logic [29:0]        nav_word,
	input logic [3:0]         word_index,
	input logic [5:0]         sat_number,
	input logic               field_valid,
	input logic               field_stall,
	input logic [4:0]         field_id,
	input logic signed [32:0] field_value,
	input logic [2:0]         subframe_number,
	input logic [1:0]         status,
	input logic               last
);

	`GLSD_ASSERT_NXT(a_hold, field_valid && field_stall, field_valid && $stable(field_id) && $stable(field_value) && $stable(status) && $stable(last), "stalled transaction changed")

	`GLSD_ASSERT_IMP(a_err_shape, field_valid && status != ST_OK, last && field_id == 5'd0 && field_value == 33'sd0, "error transaction malformed")

	`GLSD_ASSERT_IMP(a_ok_sub, field_valid && status == ST_OK, subframe_number == SF_CLOCK || subframe_number == SF_EPH_A || subframe_number == SF_EPH_B, "field from unsupported subframe")

	`GLSD_ASSERT_IMP(a_ok_last, field_valid && status == ST_OK && last, field_id == LAST_ID_SF1 || field_id == LAST_ID_SF2 || field_id == LAST_ID_SF3, "last flag on wrong field")

endmodule

bind gps_lnav_subframe_decoder_unit glsd_checker u_glsd_checker (.*);

FILE: tb/sv/gps_lnav_subframe_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS LNAV subframe decoder testbench
// Drives parity-coded navigation words, mostly as whole subframes with random
// content, with some broken words and noise. A scoreboard class holds its own
// decoder state, predicts each field or error status, and compares every
// output transaction in order. Both channels idle and stall in several phases.
// ----------------------------------------------------------------------------
module gps_lnav_subframe_decoder_unit_tb;
	import glsd_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 500;
	localparam logic [5:0] BOUND_SAT = 6'd37;

	localparam logic [23:0] PARITY_TAPS [6] = '{
		24'hEC7CD2, 24'h763E69, 24'hBB1F34, 24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27
	};
	localparam logic [5:0] TAKES_D30 = 6'b010110;

	typedef struct packed {
		int hw;
		int hs;
		int hl;
		int lw;
		int ls;
		int ll;
		int sg;
	} field_span_t;

	localparam field_span_t FIELD_MAP [30] = '{
		'{3, 1, 10, 0, 0, 0, 0}, '{3, 11, 2, 0, 0, 0, 0}, '{3, 13, 4, 0, 0, 0, 0},
		'{3, 17, 6, 0, 0, 0, 0}, '{3, 23, 2, 8, 1, 8, 0}, '{7, 17, 8, 0, 0, 0, 1},
		'{8, 9, 16, 0, 0, 0, 0}, '{9, 1, 8, 0, 0, 0, 1}, '{9, 9, 16, 0, 0, 0, 1},
		'{10, 1, 22, 0, 0, 0, 1},
		'{3, 1, 8, 0, 0, 0, 0}, '{3, 9, 16, 0, 0, 0, 1}, '{4, 1, 16, 0, 0, 0, 1},
		'{4, 17, 8, 5, 1, 24, 1}, '{6, 1, 16, 0, 0, 0, 1}, '{6, 17, 8, 7, 1, 24, 0},
		'{8, 1, 16, 0, 0, 0, 1}, '{8, 17, 8, 9, 1, 24, 0}, '{10, 1, 16, 0, 0, 0, 0},
		'{10, 17, 1, 0, 0, 0, 0}, '{10, 18, 5, 0, 0, 0, 0},
		'{3, 1, 16, 0, 0, 0, 1}, '{3, 17, 8, 4, 1, 24, 1}, '{5, 1, 16, 0, 0, 0, 1},
		'{5, 17, 8, 6, 1, 24, 1}, '{7, 1, 16, 0, 0, 0, 1}, '{7, 17, 8, 8, 1, 24, 1},
		'{9, 1, 24, 0, 0, 0, 1}, '{10, 1, 8, 0, 0, 0, 0}, '{10, 9, 14, 0, 0, 0, 1}
	};

	typedef struct packed {
		logic [4:0]  id;
		logic [32:0] value;
		logic [2:0]  subframe;
		logic [1:0]  status;
		logic        is_last;
	} field_rec_t;

	class lnav_field_ledger;
		logic [23:0] data_words [8];
		logic [1:0]  chain;
		logic [2:0]  subframe;
		bit          parity_bad;
		logic [5:0]  bound_sat;
		field_rec_t  pending [$];
		int unsigned fail_count;

		function new();
			foreach (data_words[i]) data_words[i] = '0;
			chain = '0;
			subframe = '0;
			parity_bad = 1'b0;
			bound_sat = '0;
			fail_count = 0;
		endfunction

		static function logic [5:0] parity_bits(input logic [23:0] data,
			input logic [1:0] prev);
			logic [5:0] r;
			for (int i = 0; i < 6; i++)
				r[5-i] = (^(data & PARITY_TAPS[i])) ^ (TAKES_D30[5-i] ? prev[0] : prev[1]);
			return r;
		endfunction

		function logic [23:0] bits_of(input int word, input int start, input int len);
			logic [23:0] w;
			w = data_words[(word - 3) & 7];
			return (w >> (25 - start - len)) & ~(24'hFFFFFF << len);
		endfunction

		function void close_subframe(input logic [5:0] sat);
			logic [1:0]  st;
			int          first;
			int          count;
			int          total;
			logic [63:0] v;
			field_span_t f;
			st = ST_OK;
			first = 0;
			count = 0;
			if (parity_bad) begin
				st = ST_PARITY;
			end else begin
				if (bound_sat == '0) bound_sat = sat;
				if (bound_sat != sat) begin
					st = ST_SAT;
				end else begin
					case (subframe)
						SF_CLOCK: begin
							first = FIRST_ID_SF1;
							count = LAST_ID_SF1 - FIRST_ID_SF1 + 1;
						end
						SF_EPH_A: begin
							first = FIRST_ID_SF2;
							count = LAST_ID_SF2 - FIRST_ID_SF2 + 1;
						end
						SF_EPH_B: begin
							first = FIRST_ID_SF3;
							count = LAST_ID_SF3 - FIRST_ID_SF3 + 1;
						end
						default: st = ST_SUBFRAME;
					endcase
				end
			end
			if (st != ST_OK) begin
				pending.push_back('{5'd0, 33'd0, subframe, st, 1'b1});
			end else begin
				for (int k = 0; k < count; k++) begin
					f = FIELD_MAP[first + k];
					v = {40'd0, bits_of(f.hw, f.hs, f.hl)};
					total = f.hl;
					if (f.ll != 0) begin
						v = (v << f.ll) | {40'd0, bits_of(f.lw, f.ls, f.ll)};
						total = total + f.ll;
					end
					if (f.sg != 0 && v[total-1]) v = v | ~((64'd1 << total) - 64'd1);
					pending.push_back('{5'(first + k), v[32:0], subframe, ST_OK,
						k == count - 1});
				end
			end
		endfunction

		function void take_word(input logic [29:0] w, input logic [3:0] idx,
			input logic [5:0] sat);
			logic [23:0] data;
			if (idx == TLM_INDEX) begin
				parity_bad = 1'b0;
			end else if (idx == HOW_INDEX) begin
				subframe = w[10:8];
				chain = w[1:0];
			end else if (idx <= LAST_INDEX) begin
				data = w[29:6] ^ {24{chain[0]}};
				if (parity_bits(data, chain) != w[5:0]) parity_bad = 1'b1;
				data_words[3'(idx - FIRST_DATA_INDEX)] = data;
				chain = w[1:0];
				if (idx == LAST_INDEX) begin
					close_subframe(sat);
					parity_bad = 1'b0;
				end
			end
		endfunction

		function void match_field(input logic [4:0] id, input logic [32:0] value,
			input logic [2:0] sf, input logic [1:0] st, input logic lst);
			field_rec_t e;
			if (pending.size() == 0) begin
				$error("unexpected transaction: field_id %0d field_value %0h", id, value);
				fail_count++;
				return;
			end
			e = pending.pop_front();
			if (id !== e.id) begin
				$error("field_id: expected %0d, actual %0d", e.id, id);
				fail_count++;
			end
			if (value !== e.value) begin
				$error("field_value: expected %0h, actual %0h", e.value, value);
				fail_count++;
			end
			if (sf !== e.subframe) begin
				$error("subframe_number: expected %0d, actual %0d", e.subframe, sf);
				fail_count++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				fail_count++;
			end
			if (lst !== e.is_last) begin
				$error("last: expected %0d, actual %0d", e.is_last, lst);
				fail_count++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               nav_valid;
	logic               nav_stall;
	logic [29:0]        nav_word;
	logic [3:0]         word_index;
	logic [5:0]         sat_number;
	logic               field_valid;
	logic               field_stall = 1'b0;
	logic [4:0]         field_id;
	logic signed [32:0] field_value;
	logic [2:0]         subframe_number;
	logic [1:0]         status;
	logic               last;

	lnav_field_ledger ledger;
	logic [1:0]       tx_chain;
	int               words_sent;
	int               idle_pct;
	int               stall_pct;
	int unsigned      cycles = 0;

	gps_lnav_subframe_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.nav_valid(nav_valid),
		.nav_stall(nav_stall),
		.nav_word(nav_word),
		.word_index(word_index),
		.sat_number(sat_number),
		.field_valid(field_valid),
		.field_stall(field_stall),
		.field_id(field_id),
		.field_value(field_value),
		.subframe_number(subframe_number),
		.status(status),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		field_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(negedge clk) begin
		if (arst_n && field_valid && !field_stall)
			ledger.match_field(field_id, field_value, subframe_number, status, last);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [29:0] encode_word(input logic [23:0] src);
		return {src ^ {24{tx_chain[0]}}, lnav_field_ledger::parity_bits(src, tx_chain)};
	endfunction

	task automatic send_word(input logic [29:0] w, input logic [3:0] idx,
		input logic [5:0] sat);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			nav_valid <= 1'b0;
			@(posedge clk);
		end
		nav_valid <= 1'b1;
		nav_word <= w;
		word_index <= idx;
		sat_number <= sat;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !nav_stall;
			@(posedge clk);
		end
		ledger.take_word(w, idx, sat);
		if (idx >= HOW_INDEX && idx <= LAST_INDEX) tx_chain = w[1:0];
		if (idx <= LAST_INDEX) words_sent++;
	endtask

	task automatic send_how(input logic [2:0] sf, input logic [5:0] sat);
		logic [29:0] w;
		w = 30'($urandom);
		w[10:8] = sf;
		send_word(w, HOW_INDEX, sat);
	endtask

	// flip_bit < 0 keeps the parity intact
	task automatic send_data(input logic [3:0] idx, input logic [23:0] src,
		input logic [5:0] sat, input int flip_bit);
		logic [29:0] w;
		w = encode_word(src);
		if (flip_bit >= 0) w[flip_bit] = ~w[flip_bit];
		send_word(w, idx, sat);
	endtask

	task automatic send_subframe(input logic [2:0] sf, input logic [5:0] sat,
		input bit with_tlm, input int bad_idx, input bit extremes);
		logic [23:0] src;
		if (with_tlm) send_word(30'($urandom), TLM_INDEX, sat);
		send_how(sf, sat);
		for (int i = FIRST_DATA_INDEX; i <= LAST_INDEX; i++) begin
			src = extremes ? ((i % 2 != 0) ? 24'h000000 : 24'hFFFFFF) : 24'($urandom);
			send_data(4'(i), src, sat, (i == bad_idx) ? int'($urandom_range(29)) : -1);
		end
	endtask

	initial begin
		logic [2:0] sf;
		logic [5:0] sat;
		int         roll;
		int         bad_idx;
		arst_n = 1'b0;
		nav_valid = 1'b0;
		nav_word = '0;
		word_index = '0;
		sat_number = '0;
		tx_chain = '0;
		words_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		ledger = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole store first; satellite zero leaves the tracker unbound
		send_subframe(SF_CLOCK, 6'd0, 1'b1, 0, 1'b1);
		send_word(30'h3FFFFFFF, 4'd15, 6'd63);
		send_word(30'h0, 4'(WORDS_PER_SUBFRAME), 6'd0);
		send_how(3'd5, 6'd0);
		send_data(LAST_INDEX, 24'($urandom), 6'd0, -1);
		send_word(30'($urandom), TLM_INDEX, 6'd21);
		send_how(SF_EPH_B, 6'd21);
		send_data(LAST_INDEX, 24'($urandom), 6'd21, 0);
		send_how(SF_EPH_A, BOUND_SAT);
		send_data(LAST_INDEX, 24'($urandom), BOUND_SAT, -1);
		send_how(SF_CLOCK, 6'd12);
		send_data(LAST_INDEX, 24'($urandom), 6'd12, -1);

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case ((words_sent / 64) % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 62;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 62;
				end
				default: begin
					idle_pct = 18;
					stall_pct = 18;
				end
			endcase
			roll = $urandom_range(99);
			if (roll < 15) begin
				repeat ($urandom_range(1, 4))
					send_word(30'($urandom), 4'($urandom), 6'($urandom));
			end else begin
				if (roll < 88) sf = 3'($urandom_range(SF_CLOCK, SF_EPH_B));
				else sf = 3'($urandom_range(4, 8));
				sat = ($urandom_range(9) == 0) ? 6'($urandom) : BOUND_SAT;
				bad_idx = ($urandom_range(9) == 0) ?
					int'($urandom_range(FIRST_DATA_INDEX, LAST_INDEX)) : 0;
				send_subframe(sf, sat, $urandom_range(9) != 0, bad_idx, 1'b0);
			end
		end

		nav_valid <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (ledger.fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
